@@ rtl/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, constants and arithmetic helpers of the cubic temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package ctc_pkg;

   // Pipeline depth: front, three prescale/multiply rounds, scale, sum.
   localparam int NUM_STAGES = 9;

   localparam int TEMP_W  = 16;
   localparam int COEF_W  = 32;
   localparam int CORR_W  = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [TEMP_W-1:0] BASE_ALL_ONES = 16'hFFFF;
   localparam logic [TEMP_W-1:0] BASE_ZERO     = 16'h0000;

   localparam logic [5:0] SIG_LIMIT      = 6'd32;
   localparam logic [5:0] PRESCALE_STEP  = 6'd10;
   localparam logic [5:0] TARGET_SCALE   = 6'd30;
   localparam int         TERM_SHIFT     = 10;

   localparam logic signed [COEF_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_W-1:0] ACC_MIN = 32'sh8000_0000;
   localparam logic signed [COEF_W-1:0] CORR_MAX32 = 32'sd32767;
   localparam logic signed [COEF_W-1:0] CORR_MIN32 = -32'sd32768;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_BASE  = 3'd0,
      CSR_COEF_ZERO  = 3'd1,
      CSR_COEF_ONE   = 3'd2,
      CSR_COEF_TWO   = 3'd3,
      CSR_COEF_THREE = 3'd4
   } ctc_csr_type;

   // Per-item context that travels down the cubic path.
   typedef struct packed {
      logic signed [TEMP_W-1:0] d;
      logic [4:0]               sbd;
      logic                     inv;
      logic signed [COEF_W-1:0] acc;
      logic [5:0]               shift;
   } ctc_stage_type;

   // Significant bits of a two's complement word: bit length of the
   // magnitude pattern plus one for a negative value.
   function automatic logic [5:0] sig_bits(input logic [COEF_W-1:0] v);
      logic [COEF_W-1:0] m;
      logic [5:0]        n;
      m = v[COEF_W-1] ? ~v : v;
      n = '0;
      for (int i = 0; i < COEF_W; i++) begin
         if (m[i]) begin
            n = 6'(i + 1);
         end
      end
      return n + {5'b0, v[COEF_W-1]};
   endfunction

   // Significant bits left after an arithmetic right shift by ten.
   function automatic logic [5:0] sig_bits_shifted(input logic [5:0] sb,
                                                   input logic       neg);
      logic [5:0] r;
      if (neg) begin
         r = (sb > 6'd11) ? sb - PRESCALE_STEP : 6'd1;
      end else begin
         r = (sb > 6'd10) ? sb - PRESCALE_STEP : 6'd0;
      end
      return r;
   endfunction

endpackage

@@ rtl/ctc_if.sv @@
// ----------------------------------------------------------------------------
// ctc_req_if / ctc_rsp_if
// Valid/ready channels carrying a raw reading in and a correction out.
// ----------------------------------------------------------------------------
interface ctc_req_if import ctc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] raw_temp;

   modport source (output valid, output raw_temp, input ready);
   modport sink   (input valid, input raw_temp, output ready);
endinterface

interface ctc_rsp_if import ctc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CORR_W-1:0] correction;
   logic                     params_invalid;

   modport source (output valid, output correction, output params_invalid,
                   input ready);
   modport sink   (input valid, input correction, input params_invalid,
                   output ready);
endinterface

@@ rtl/ctc_front.sv @@
// ----------------------------------------------------------------------------
// ctc_front
// First stage: offset from the base, its significant bits, validity of the
// base, and the cubic accumulator seeded with the cubic coefficient.
// ----------------------------------------------------------------------------
module ctc_front import ctc_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [TEMP_W-1:0]        raw_temp,
   input  logic [TEMP_W-1:0]        temp_base,
   input  logic signed [COEF_W-1:0] coef_three,
   output ctc_stage_type            stage_out
);

   ctc_stage_type stage_ff;
   ctc_stage_type stage_in;
   logic [TEMP_W-1:0] diff;
   logic [5:0]        sbd_full;

   // Wrap offset to 16 bits and size it.
   always_comb begin
      diff           = raw_temp - temp_base;
      sbd_full       = sig_bits({{(COEF_W-TEMP_W){diff[TEMP_W-1]}}, diff});
      stage_in.d     = $signed(diff);
      stage_in.sbd   = sbd_full[4:0];
      stage_in.inv   = (temp_base == BASE_ZERO) || (temp_base == BASE_ALL_ONES);
      stage_in.acc   = coef_three;
      stage_in.shift = '0;
   end

   // Load on advance.
   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

@@ rtl/ctc_cube_round.sv @@
// ----------------------------------------------------------------------------
// ctc_cube_round
// One round of the cubic term: a prescale stage that drops ten bits up to
// twice while the product would overflow, then a multiply stage by d.
// ----------------------------------------------------------------------------
module ctc_cube_round import ctc_pkg::*; (
   input  logic          clock,
   input  logic          en_pre,
   input  logic          en_mul,
   input  ctc_stage_type stage_in,
   output ctc_stage_type stage_out
);

   localparam int PROD_W = COEF_W + TEMP_W;

   ctc_stage_type pre_ff, pre_in;
   ctc_stage_type mul_ff, mul_in;
   logic [5:0] sb0, sb1, sbd6;
   logic       cut0, cut1;
   logic [4:0] amount;
   logic signed [PROD_W-1:0] product;

   // Prescale: two conditional arithmetic shifts by ten.
   always_comb begin
      sbd6   = {1'b0, stage_in.sbd};
      sb0    = sig_bits(stage_in.acc);
      cut0   = (sb0 + sbd6) >= SIG_LIMIT;
      sb1    = cut0 ? sig_bits_shifted(sb0, stage_in.acc[COEF_W-1]) : sb0;
      cut1   = (sb1 + sbd6) >= SIG_LIMIT;
      unique case ({cut0, cut1})
         2'b11:          amount = 5'd20;
         2'b10, 2'b01:   amount = 5'd10;
         default:        amount = 5'd0;
      endcase
      pre_in       = stage_in;
      pre_in.acc   = stage_in.acc >>> amount;
      pre_in.shift = stage_in.shift + {1'b0, amount};
   end

   // Multiply: keep the low 32 bits of acc * d.
   always_comb begin
      product    = PROD_W'(pre_ff.acc) * PROD_W'(pre_ff.d);
      mul_in     = pre_ff;
      mul_in.acc = product[COEF_W-1:0];
   end

   // Advance both stages.
   always_ff @(posedge clock) begin
      if (en_pre) begin
         pre_ff <= pre_in;
      end
      if (en_mul) begin
         mul_ff <= mul_in;
      end
   end

   assign stage_out = mul_ff;

endmodule

@@ rtl/ctc_lower.sv @@
// ----------------------------------------------------------------------------
// ctc_lower
// Quadratic, linear and constant terms, folded into one word and delayed
// to line up with the scaled cubic term.
// ----------------------------------------------------------------------------
module ctc_lower import ctc_pkg::*; (
   input  logic                     clock,
   input  logic [NUM_STAGES-1:2]    en,
   input  logic signed [TEMP_W-1:0] d_first,
   input  logic signed [COEF_W-1:0] coef_zero,
   input  logic signed [COEF_W-1:0] coef_one,
   input  logic signed [COEF_W-1:0] coef_two,
   output logic signed [COEF_W-1:0] poly
);

   localparam int PROD_W = COEF_W + TEMP_W;

   logic signed [COEF_W-1:0] quad_a_ff, lin_a_ff;
   logic signed [TEMP_W-1:0] d_a_ff;
   logic signed [COEF_W-1:0] quad_b_ff, lin_b_ff;
   logic signed [COEF_W-1:0] poly_ff [4:8];
   logic signed [PROD_W-1:0] quad_a_in, lin_a_in, quad_b_in;
   logic signed [COEF_W-1:0] quad_a_sh;

   // Products of the first and second quadratic step and the linear step.
   always_comb begin
      quad_a_in = PROD_W'(coef_two) * PROD_W'(d_first);
      lin_a_in  = PROD_W'(coef_one) * PROD_W'(d_first);
      quad_a_sh = quad_a_ff >>> TERM_SHIFT;
      quad_b_in = PROD_W'(quad_a_sh) * PROD_W'(d_a_ff);
   end

   // Advance the term stages and the alignment delay.
   always_ff @(posedge clock) begin
      if (en[2]) begin
         quad_a_ff <= quad_a_in[COEF_W-1:0];
         lin_a_ff  <= lin_a_in[COEF_W-1:0];
         d_a_ff    <= d_first;
      end
      if (en[3]) begin
         quad_b_ff <= quad_b_in[COEF_W-1:0];
         lin_b_ff  <= (lin_a_ff >>> TERM_SHIFT) + coef_zero;
      end
      if (en[4]) begin
         poly_ff[4] <= (quad_b_ff >>> TERM_SHIFT) + lin_b_ff;
      end
      for (int k = 5; k <= 8; k++) begin
         if (en[k]) begin
            poly_ff[k] <= poly_ff[k-1];
         end
      end
   end

   assign poly = poly_ff[8];

endmodule

@@ rtl/ctc_finish.sv @@
// ----------------------------------------------------------------------------
// ctc_finish
// Rescale the cubic accumulator to 2^30, then add the lower terms and clamp
// to 16 bits into the output register.
// ----------------------------------------------------------------------------
module ctc_finish import ctc_pkg::*; (
   input  logic                     clock,
   input  logic                     en_scale,
   input  logic                     en_out,
   input  ctc_stage_type            stage_in,
   input  logic signed [COEF_W-1:0] poly,
   output logic signed [CORR_W-1:0] correction,
   output logic                     params_invalid
);

   logic signed [COEF_W-1:0] cube_ff, cube_in;
   logic                     inv_ff;
   logic signed [CORR_W-1:0] corr_ff, corr_in;
   logic                     invalid_ff;
   logic [5:0]               excess;
   logic [4:0]               lshift;
   logic signed [COEF_W-1:0] high_part;
   logic                     fits;
   logic signed [COEF_W-1:0] total;

   // Undo the prescale: right shift toward 2^30, or saturating left shift.
   always_comb begin
      excess    = stage_in.shift - TARGET_SCALE;
      lshift    = excess[4:0];
      high_part = stage_in.acc >>> (5'd31 - lshift);
      fits      = (high_part == '0) || (high_part == '1);
      if (stage_in.shift <= TARGET_SCALE) begin
         cube_in = stage_in.acc >>> (5'(TARGET_SCALE - stage_in.shift));
      end else if (fits) begin
         cube_in = stage_in.acc <<< lshift;
      end else begin
         cube_in = stage_in.acc[COEF_W-1] ? ACC_MIN : ACC_MAX;
      end
   end

   // Sum and clamp; an invalid base forces zero.
   always_comb begin
      total = cube_ff + poly;
      priority if (inv_ff) begin
         corr_in = '0;
      end else if (total >= CORR_MAX32) begin
         corr_in = CORR_MAX32[CORR_W-1:0];
      end else if (total <= CORR_MIN32) begin
         corr_in = CORR_MIN32[CORR_W-1:0];
      end else begin
         corr_in = total[CORR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_scale) begin
         cube_ff <= cube_in;
         inv_ff  <= stage_in.inv;
      end
      if (en_out) begin
         corr_ff    <= corr_in;
         invalid_ff <= inv_ff;
      end
   end

   assign correction     = corr_ff;
   assign params_invalid = invalid_ff;

endmodule

@@ rtl/cubic_temp_compensation.sv @@
// ----------------------------------------------------------------------------
// cubic_temp_compensation
// Top level: configuration registers, stage valid/advance control and the
// compensation pipeline.
// ----------------------------------------------------------------------------
// Takes one raw reading per cycle unless backpressure holds the pipeline,
// and returns one 16-bit signed correction per reading, in order. The
// depth is set by the three prescale/multiply rounds of the cubic term,
// each two stages, plus an offset stage in front and a rescale stage and
// a sum/clamp output register behind, from which the result is presented.
// Each stage holds its word under backpressure and a free stage takes the
// next word, so bubbles close up and input is taken while a result waits.
// A base of 0 or 0xFFFF gives a zero correction with params_invalid set.
// The user must see that registers are written through the csr_ port only
// while the pipeline is empty; the block itself does not enforce this.
module cubic_temp_compensation import ctc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ctc_req_if.sink              req_chan,
   ctc_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   logic [TEMP_W-1:0]        temp_base_ff;
   logic signed [COEF_W-1:0] coef_zero_ff, coef_one_ff, coef_two_ff, coef_three_ff;
   logic [NUM_STAGES:1]      valid_ff;
   logic [NUM_STAGES:1]      en;
   ctc_stage_type            st1, st3, st5, st7;
   logic signed [COEF_W-1:0] poly;

   // Write configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_base_ff  <= '0;
         coef_zero_ff  <= '0;
         coef_one_ff   <= '0;
         coef_two_ff   <= '0;
         coef_three_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEMP_BASE:  temp_base_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_COEF_ZERO:  coef_zero_ff  <= csr_wdata;
            CSR_COEF_ONE:   coef_one_ff   <= csr_wdata;
            CSR_COEF_TWO:   coef_two_ff   <= csr_wdata;
            CSR_COEF_THREE: coef_three_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A stage advances when it is empty or its successor advances.
   always_comb begin
      en[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   // Move valid bits with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_chan.valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_chan.ready = en[1];
   assign rsp_chan.valid = valid_ff[NUM_STAGES];

   ctc_front u_front (
      .clock      (clock),
      .en         (en[1]),
      .raw_temp   (req_chan.raw_temp),
      .temp_base  (temp_base_ff),
      .coef_three (coef_three_ff),
      .stage_out  (st1)
   );

   ctc_cube_round u_round1 (
      .clock     (clock),
      .en_pre    (en[2]),
      .en_mul    (en[3]),
      .stage_in  (st1),
      .stage_out (st3)
   );

   ctc_cube_round u_round2 (
      .clock     (clock),
      .en_pre    (en[4]),
      .en_mul    (en[5]),
      .stage_in  (st3),
      .stage_out (st5)
   );

   ctc_cube_round u_round3 (
      .clock     (clock),
      .en_pre    (en[6]),
      .en_mul    (en[7]),
      .stage_in  (st5),
      .stage_out (st7)
   );

   ctc_lower u_lower (
      .clock     (clock),
      .en        (en[NUM_STAGES-1:2]),
      .d_first   (st1.d),
      .coef_zero (coef_zero_ff),
      .coef_one  (coef_one_ff),
      .coef_two  (coef_two_ff),
      .poly      (poly)
   );

   ctc_finish u_finish (
      .clock          (clock),
      .en_scale       (en[8]),
      .en_out         (en[9]),
      .stage_in       (st7),
      .poly           (poly),
      .correction     (rsp_chan.correction),
      .params_invalid (rsp_chan.params_invalid)
   );

endmodule

@@ bench/cubic_temp_compensation_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_temp_compensation_tb
// Self-checking bench for the cubic temperature compensation pipeline.
// A scoreboard class keeps its own copy of the registers and computes each
// correction from the accepted reading. Results are matched in order,
// field by field. Directed readings hit the invalid bases, the extreme
// offsets and the extreme coefficients. Random phases then vary the
// settings, the readings and the stalls on both channels.
// ----------------------------------------------------------------------------
module cubic_temp_compensation_tb import ctc_pkg::*; ();

   localparam int RX_HOLD_CYCLES = 64;
   localparam int RAND_PHASES    = 12;
   localparam int PHASE_WORDS    = 100;
   localparam int BURST_WORDS    = 60;

   typedef struct {
      logic signed [CORR_W-1:0] correction;
      logic                     params_invalid;
   } correction_type;

   // Scoreboard: register copy, correction model and in-order result queue
   class compensation_checker;
      logic [TEMP_W-1:0]        base_reg;
      logic signed [COEF_W-1:0] zero_term;
      logic signed [COEF_W-1:0] lin_coef;
      logic signed [COEF_W-1:0] quad_coef;
      logic signed [COEF_W-1:0] cubic_coef;
      correction_type           pending_corrections[$];
      int                       errors;
      int                       checked;
      int                       invalid_seen;

      function new();
         base_reg   = '0;
         zero_term  = '0;
         lin_coef   = '0;
         quad_coef  = '0;
         cubic_coef = '0;
         errors       = 0;
         checked      = 0;
         invalid_seen = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
         case (ctc_csr_type'(idx))
            CSR_TEMP_BASE:  base_reg   = val[TEMP_W-1:0];
            CSR_COEF_ZERO:  zero_term  = val;
            CSR_COEF_ONE:   lin_coef   = val;
            CSR_COEF_TWO:   quad_coef  = val;
            CSR_COEF_THREE: cubic_coef = val;
            default: ;
         endcase
      endfunction

      // Bit length of the magnitude pattern, plus one for a negative value
      function int unsigned signif_bits(logic signed [COEF_W-1:0] v);
         logic [COEF_W-1:0] m;
         int unsigned       n;
         m = v[COEF_W-1] ? ~v : v;
         n = 0;
         for (int i = 0; i < COEF_W; i++) begin
            if (m[i]) begin
               n = i + 1;
            end
         end
         return n + v[COEF_W-1];
      endfunction

      function correction_type compute_correction(logic [TEMP_W-1:0] raw);
         correction_type           r;
         logic [TEMP_W-1:0]        diff;
         logic signed [COEF_W-1:0] d, acc, prod, quad, lin, sum;
         int unsigned              scale;
         longint                   wide;
         r.correction     = '0;
         r.params_invalid = 1'b0;
         if (base_reg == BASE_ZERO || base_reg == BASE_ALL_ONES) begin
            r.params_invalid = 1'b1;
            return r;
         end
         diff = raw - base_reg;
         d    = {{(COEF_W-TEMP_W){diff[TEMP_W-1]}}, diff};

         // Cubic term: prescale the accumulator before each multiply
         acc   = cubic_coef;
         scale = 0;
         repeat (3) begin
            repeat (2) begin
               if (signif_bits(acc) + signif_bits(d) >= SIG_LIMIT) begin
                  acc   = acc >>> PRESCALE_STEP;
                  scale = scale + PRESCALE_STEP;
               end
            end
            acc = acc * d;
         end
         // Bring the cubic term back to a scale of 2^30
         if (scale <= TARGET_SCALE) begin
            acc = acc >>> (TARGET_SCALE - scale);
         end else begin
            wide = longint'(acc) <<< (scale - TARGET_SCALE);
            if (wide > longint'(ACC_MAX)) begin
               acc = ACC_MAX;
            end else if (wide < longint'(ACC_MIN)) begin
               acc = ACC_MIN;
            end else begin
               acc = wide[COEF_W-1:0];
            end
         end

         prod = quad_coef * d;
         quad = prod >>> TERM_SHIFT;
         prod = quad * d;
         quad = prod >>> TERM_SHIFT;
         prod = lin_coef * d;
         lin  = prod >>> TERM_SHIFT;
         sum  = quad + acc + lin + zero_term;

         // Clamp to the 16-bit output range
         if (sum >= CORR_MAX32) begin
            r.correction = CORR_W'(CORR_MAX32);
         end else if (sum <= CORR_MIN32) begin
            r.correction = CORR_W'(CORR_MIN32);
         end else begin
            r.correction = sum[CORR_W-1:0];
         end
         return r;
      endfunction

      function void note_reading(logic [TEMP_W-1:0] raw);
         pending_corrections.push_back(compute_correction(raw));
      endfunction

      function int pending();
         return pending_corrections.size();
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_correction(logic signed [CORR_W-1:0] corr, logic inv);
         correction_type want;
         if (pending_corrections.size() == 0) begin
            report_mismatch($sformatf("unexpected word corr=%0d inv=%0b", corr, inv));
            return;
         end
         want = pending_corrections.pop_front();
         checked++;
         if (inv) begin
            invalid_seen++;
         end
         if (corr !== want.correction) begin
            report_mismatch($sformatf("word %0d correction got %0d want %0d",
                                      checked, corr, want.correction));
         end
         if (inv !== want.params_invalid) begin
            report_mismatch($sformatf("word %0d params_invalid got %0b want %0b",
                                      checked, inv, want.params_invalid));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   ctc_req_if req_if ();
   ctc_rsp_if rsp_if ();

   compensation_checker sb = new();

   bit tx_gaps_on   = 1'b1;
   bit rx_gaps_on   = 1'b1;
   bit rx_long_hold = 1'b0;
   int words_sent   = 0;
   int settings_run = 0;

   cubic_temp_compensation u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 8) begin
         return 0;
      end else if (r < 14) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef();
      logic [COEF_W-1:0] v;
      int                n;
      case ($urandom_range(0, 7))
         0: v = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: v = ACC_MAX;
               1: v = ACC_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: begin
            n = $urandom_range(1, 24);
            v = $urandom_range(0, (1 << n) - 1);
            if ($urandom_range(0, 1)) begin
               v = -v;
            end
         end
      endcase
      return v;
   endfunction

   // Readings mostly near the base, the rest anywhere
   function automatic logic [TEMP_W-1:0] rand_reading(logic [TEMP_W-1:0] base);
      logic [TEMP_W-1:0] off;
      if ($urandom_range(0, 2) == 0) begin
         return TEMP_W'($urandom);
      end
      off = TEMP_W'($urandom_range(0, (1 << $urandom_range(0, 15)) - 1));
      return $urandom_range(0, 1) ? base + off : base - off;
   endfunction

   // Write all five registers, then optionally the unused indexes
   task automatic apply_settings(logic [TEMP_W-1:0] base, logic [COEF_W-1:0] c0,
                                 logic [COEF_W-1:0] c1, logic [COEF_W-1:0] c2,
                                 logic [COEF_W-1:0] c3, bit spare);
      logic [COEF_W-1:0] vals[5];
      logic [COEF_W-1:0] junk;
      vals[CSR_TEMP_BASE]  = {16'($urandom), base};
      vals[CSR_COEF_ZERO]  = c0;
      vals[CSR_COEF_ONE]   = c1;
      vals[CSR_COEF_TWO]   = c2;
      vals[CSR_COEF_THREE] = c3;
      for (int i = CSR_TEMP_BASE; i <= CSR_COEF_THREE; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         sb.set_register(CSR_IDX_W'(i), vals[i]);
         @(posedge clock);
      end
      if (spare) begin
         for (int i = CSR_COEF_THREE + 1; i < 2**CSR_IDX_W; i++) begin
            junk = $urandom;
            csr_wr_en <= 1'b1;
            csr_index <= CSR_IDX_W'(i);
            csr_wdata <= junk;
            sb.set_register(CSR_IDX_W'(i), junk);
            @(posedge clock);
         end
      end
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   // Offer one reading and hold it until taken, then maybe drop valid a while
   task automatic send_reading(logic [TEMP_W-1:0] raw, bit gaps);
      int gap;
      req_if.valid    <= 1'b1;
      req_if.raw_temp <= raw;
      do @(posedge clock); while (!req_if.ready);
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain the pipeline and let it go idle before touching registers;
   // one edge first so the last accepted word is already noted
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   // Count accepted readings and predict their corrections
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         sb.note_reading(req_if.raw_temp);
         words_sent++;
      end
   end

   // Check each delivered correction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_correction(rsp_if.correction, rsp_if.params_invalid);
      end
   end

   // Result side: random ready, with one long hold when asked
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            rx_long_hold = 1'b0;
         end
         gap = rx_gaps_on ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Stimulus
   initial begin
      logic [TEMP_W-1:0] base;
      bit                burst;
      req_if.valid    = 1'b0;
      req_if.raw_temp = '0;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      reset           = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: base zero is invalid
      send_reading(16'h0000, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      settle();

      // Base all ones is invalid too, whatever the coefficients
      apply_settings(BASE_ALL_ONES, $urandom, $urandom, $urandom, $urandom, 1'b0);
      send_reading(16'h1234, 1'b1);
      send_reading(16'hA5A5, 1'b1);
      settle();

      // Mid-scale base, unit coefficients: zero offset, +-1, extreme offsets
      apply_settings(16'h8000, 32'sd100, 32'sd1 <<< 10, 32'sd1 <<< 20,
                     32'sd1 <<< 30, 1'b1);
      send_reading(16'h8000, 1'b1);
      send_reading(16'h8001, 1'b1);
      send_reading(16'h7FFF, 1'b1);
      send_reading(16'h8010, 1'b1);
      send_reading(16'h0000, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      settle();

      // Lowest valid base, extreme coefficients one way
      apply_settings(16'h0001, ACC_MIN, ACC_MAX, ACC_MIN, ACC_MAX, 1'b0);
      send_reading(16'h0000, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      send_reading(16'h0001, 1'b1);
      send_reading(16'h8001, 1'b1);
      send_reading(16'h0100, 1'b1);
      settle();

      // Highest valid base, extreme coefficients the other way
      apply_settings(16'hFFFE, ACC_MAX, ACC_MIN, ACC_MAX, ACC_MIN, 1'b0);
      send_reading(16'hFFFE, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      send_reading(16'h0000, 1'b1);
      send_reading(16'h7FFE, 1'b1);
      send_reading(16'h4000, 1'b1);
      settle();

      // Random phases, each with fresh settings
      for (int p = 0; p < RAND_PHASES; p++) begin
         if ($urandom_range(0, 7) == 0) begin
            base = $urandom_range(0, 1) ? BASE_ZERO : BASE_ALL_ONES;
         end else begin
            base = TEMP_W'($urandom_range(1, 16'hFFFE));
         end
         apply_settings(base, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                        $urandom_range(0, 3) == 0);
         tx_gaps_on = (p % 4 != 1);
         rx_gaps_on = (p % 4 != 1) && (p % 4 != 3);
         if (p == 2) begin
            rx_long_hold = 1'b1;
         end
         for (int i = 0; i < PHASE_WORDS; i++) begin
            burst = (p == 2) && (i < BURST_WORDS);
            send_reading(rand_reading(base), tx_gaps_on && !burst);
            // Hold the sender until every correction is back
            if (p == 3 && i == PHASE_WORDS / 2) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (sb.pending() != 0) @(posedge clock);
            end
         end
         settle();
      end

      $display("Covered %0d readings under %0d register settings, incl. invalid bases",
               words_sent, settings_run);
      $display("Checked %0d corrections, %0d flagged invalid, with stalls on both sides",
               sb.checked, sb.invalid_seen);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timeout with %0d corrections outstanding", sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
